// ===== rtl/vps_pkg.sv =====
// Package for the viewport pixel streamer: payload structs, configuration
// struct, rotation codes and register indexes. No dependencies.
package vps_pkg;

   localparam int DEF_PANEL_WIDTH  = 128;
   localparam int DEF_PANEL_HEIGHT = 32;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_LEFT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_TOP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_RIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEW_BOTTOM = 3'd4;

   localparam logic [3:0] MAX_BITS = 4'd8;
   localparam logic       OP_STREAM = 1'b0;
   localparam logic       OP_POINT  = 1'b1;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic [3:0] bit_count;
      logic       invert;
      logic [7:0] point_x;
      logic [7:0] point_y;
      logic [7:0] level;
   } req_type;

   typedef struct packed {
      logic [7:0] pix_x;
      logic [7:0] pix_y;
      logic       pixel_on;
      logic       last;
   } rsp_type;

   typedef struct packed {
      rot_type    rotation;
      logic [7:0] view_left;
      logic [7:0] view_top;
      logic [7:0] view_right;
      logic [7:0] view_bottom;
   } cfg_type;

endpackage

// ===== rtl/vps_cursor.sv =====
// Cursor registers and viewport stepping for the pixel streamer.
// Depends on vps_pkg.
module vps_cursor (
   input  logic              clock,
   input  logic              reset,
   input  vps_pkg::cfg_type  cfg,
   input  logic              view_wr,
   input  logic              step,
   output logic [7:0]        cursor_x,
   output logic [7:0]        cursor_y
);
   import vps_pkg::*;

   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [8:0] nx9;
   logic [8:0] ny9;

   always_comb begin
      nx9 = {1'b0, x_ff} + 9'd1;
      ny9 = {1'b0, y_ff};
      x_in = x_ff;
      y_in = y_ff;
      if (nx9 > {1'b0, cfg.view_right}) begin
         nx9 = {1'b0, cfg.view_left};
         ny9 = ny9 + 9'd1;
      end
      if (ny9 > {1'b0, cfg.view_bottom}) begin
         ny9 = {1'b0, cfg.view_top};
      end
      if (view_wr) begin
         x_in = cfg.view_left;
         y_in = cfg.view_top;
      end else if (step) begin
         x_in = nx9[7:0];
         y_in = ny9[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= 8'd0;
         y_ff <= 8'd0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign cursor_x = x_ff;
   assign cursor_y = y_ff;

endmodule

// ===== rtl/vps_rotate.sv =====
// Logical-to-panel coordinate rotation, modulo 256.
// Depends on vps_pkg.
module vps_rotate #(
   parameter int PANEL_WIDTH  = vps_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = vps_pkg::DEF_PANEL_HEIGHT
) (
   input  vps_pkg::rot_type rotation,
   input  logic [7:0]       lx,
   input  logic [7:0]       ly,
   output logic [7:0]       px,
   output logic [7:0]       py
);
   import vps_pkg::*;

   localparam logic [7:0] W_M1 = 8'(PANEL_WIDTH - 1);
   localparam logic [7:0] H_M1 = 8'(PANEL_HEIGHT - 1);

   always_comb begin
      case (rotation)
         ROT_90: begin
            px = W_M1 - ly;
            py = lx;
         end
         ROT_180: begin
            px = W_M1 - lx;
            py = H_M1 - ly;
         end
         ROT_270: begin
            px = ly;
            py = H_M1 - lx;
         end
         default: begin
            px = lx;
            py = ly;
         end
      endcase
   end

endmodule

// ===== rtl/viewport_pixel_streamer_rotate.sv =====
// Top level of the viewport pixel streamer: item register, bit sequencer,
// configuration registers and result register. Depends on vps_pkg,
// vps_cursor and vps_rotate.
//
//   channel | direction | ports                              | handshake
//   req     | in        | req_valid req_ready req_data       | valid/ready
//   rsp     | out       | rsp_valid rsp_ready rsp_data       | valid/ready
//   csr     | in        | csr_valid csr_ready csr_index csr_data | valid/ready
//
// A stream byte gives one pixel transfer per cycle when the result is not stalled,
// bit_count of them (8 at most); a point write gives a single pixel.
// The next item is taken in the cycle its predecessor's last pixel moves out, so
// the item register never takes a new item while the current one has pixels left.
// A stream byte with zero bit count is taken and dropped without a pixel.
// Synchronous reset clears the handshake state and cursor and resets the config.
// A stalled result holds in the result register and stalls the sequencer behind it.
module viewport_pixel_streamer_rotate #(
   parameter int PANEL_WIDTH  = vps_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = vps_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vps_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vps_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_data
);
   import vps_pkg::*;

   // configuration
   cfg_type cfg_ff, cfg_in;
   logic    csr_fire;
   logic    view_wr;

   // item register and bit sequencer
   logic       busy_ff, busy_in;
   req_type    item_ff, item_in;
   logic [2:0] idx_ff, idx_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic       req_fire;
   logic       out_free;
   logic       emit;
   logic       is_last;
   logic [3:0] clamp_count;
   logic [7:0] cur_x, cur_y;
   logic [7:0] lx, ly;
   logic [7:0] px, py;
   logic       pix_on;

   // Configuration writes are to land only while idle; the block does not enforce it.
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      cfg_in  = cfg_ff;
      view_wr = 1'b0;
      if (csr_fire) begin
         case (csr_index)
            CSR_ROTATION:    cfg_in.rotation = rot_type'(csr_data[1:0]);
            CSR_VIEW_LEFT: begin
               cfg_in.view_left = csr_data;
               view_wr          = 1'b1;
            end
            CSR_VIEW_TOP: begin
               cfg_in.view_top = csr_data;
               view_wr         = 1'b1;
            end
            CSR_VIEW_RIGHT: begin
               cfg_in.view_right = csr_data;
               view_wr           = 1'b1;
            end
            CSR_VIEW_BOTTOM: begin
               cfg_in.view_bottom = csr_data;
               view_wr            = 1'b1;
            end
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   // Emit a pixel whenever busy and the result register is free or draining.
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign is_last  = (item_ff.op == OP_POINT) ||
                     (({1'b0, idx_ff} + 4'd1) == item_ff.bit_count);

   // Take a new item when empty or as the last pixel of the current one leaves.
   assign req_ready = !busy_ff || (emit && is_last);
   assign req_fire  = req_valid && req_ready;

   assign clamp_count = (req_data.bit_count > MAX_BITS) ? MAX_BITS : req_data.bit_count;

   always_comb begin
      item_in = item_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (req_fire) begin
         item_in           = req_data;
         item_in.bit_count = clamp_count;
         idx_in            = 3'd0;
         // drop a stream byte that carries no pixels
         busy_in = (req_data.op == OP_POINT) || (clamp_count != 4'd0);
      end else if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Home the cursor on the viewport corner as it stands after the write.
   vps_cursor u_cursor (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_in),
      .view_wr  (view_wr),
      .step     (emit && (item_ff.op == OP_STREAM)),
      .cursor_x (cur_x),
      .cursor_y (cur_y)
   );

   assign lx = (item_ff.op == OP_POINT) ? item_ff.point_x : cur_x;
   assign ly = (item_ff.op == OP_POINT) ? item_ff.point_y : cur_y;

   vps_rotate #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_rotate (
      .rotation (cfg_ff.rotation),
      .lx       (lx),
      .ly       (ly),
      .px       (px),
      .py       (py)
   );

   // Point writes light at level 128 and above; stream bits go out LSB first.
   assign pix_on = (item_ff.op == OP_POINT) ? item_ff.level[7]
                                            : (item_ff.data_byte[idx_ff] ^ item_ff.invert);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.pix_x    = px;
         out_in.pix_y    = py;
         out_in.pixel_on = pix_on;
         out_in.last     = is_last;
         out_valid_in    = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation    <= ROT_0;
         cfg_ff.view_left   <= 8'd0;
         cfg_ff.view_top    <= 8'd0;
         cfg_ff.view_right  <= 8'd127;
         cfg_ff.view_bottom <= 8'd31;
         busy_ff            <= 1'b0;
         idx_ff             <= 3'd0;
         out_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== tb/vps_tb_pkg.sv =====
`timescale 1ns / 1ps
// Pixel write tracker for the viewport pixel streamer testbench: predicts the
// panel writes of each accepted item and checks them in order. Depends on vps_pkg.
package vps_tb_pkg;
   import vps_pkg::*;

   class pixel_write_tracker;
      rot_type     rot;
      logic [7:0]  left, top, right, bottom;
      logic [7:0]  cur_x, cur_y;
      rsp_type     pending_pixels[$];
      int unsigned faults;

      function new();
         rot    = ROT_0;
         left   = 8'd0;
         top    = 8'd0;
         right  = 8'd127;
         bottom = 8'd31;
         cur_x  = 8'd0;
         cur_y  = 8'd0;
         faults = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] val);
         case (idx)
            CSR_ROTATION: begin
               rot = rot_type'(val[1:0]);
               return;
            end
            CSR_VIEW_LEFT:   left   = val;
            CSR_VIEW_TOP:    top    = val;
            CSR_VIEW_RIGHT:  right  = val;
            CSR_VIEW_BOTTOM: bottom = val;
            default: return;
         endcase
         cur_x = left;
         cur_y = top;
      endfunction

      // logical point to panel point, all mod 256
      function rsp_type panel_pixel(logic [7:0] lx, logic [7:0] ly, logic on, logic fin);
         logic [7:0] w_edge;
         logic [7:0] h_edge;
         rsp_type    p;
         w_edge = 8'(DEF_PANEL_WIDTH - 1);
         h_edge = 8'(DEF_PANEL_HEIGHT - 1);
         case (rot)
            ROT_90: begin
               p.pix_x = w_edge - ly;
               p.pix_y = lx;
            end
            ROT_180: begin
               p.pix_x = w_edge - lx;
               p.pix_y = h_edge - ly;
            end
            ROT_270: begin
               p.pix_x = ly;
               p.pix_y = h_edge - lx;
            end
            default: begin
               p.pix_x = lx;
               p.pix_y = ly;
            end
         endcase
         p.pixel_on = on;
         p.last     = fin;
         return p;
      endfunction

      // compares in 9 bits so an inverted viewport just wraps every step
      function void advance_cursor();
         logic [8:0] nx;
         logic [8:0] ny;
         nx = {1'b0, cur_x} + 9'd1;
         ny = {1'b0, cur_y};
         if (nx > {1'b0, right}) begin
            nx = {1'b0, left};
            ny = ny + 9'd1;
         end
         if (ny > {1'b0, bottom})
            ny = {1'b0, top};
         cur_x = nx[7:0];
         cur_y = ny[7:0];
      endfunction

      function void note_request(req_type r);
         logic [3:0] count;
         if (r.op == OP_POINT) begin
            pending_pixels.push_back(panel_pixel(r.point_x, r.point_y, r.level[7], 1'b1));
            return;
         end
         count = (r.bit_count > MAX_BITS) ? MAX_BITS : r.bit_count;
         for (int i = 0; i < count; i++) begin
            pending_pixels.push_back(panel_pixel(cur_x, cur_y, r.data_byte[i] ^ r.invert,
                                                 i == count - 1));
            advance_cursor();
         end
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            $error("pixel write with none outstanding: pix_x %0d pix_y %0d",
                   got.pix_x, got.pix_y);
            faults++;
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pix_x !== want.pix_x) begin
            $error("pix_x: expected %0d, actual %0d", want.pix_x, got.pix_x);
            faults++;
         end
         if (got.pix_y !== want.pix_y) begin
            $error("pix_y: expected %0d, actual %0d", want.pix_y, got.pix_y);
            faults++;
         end
         if (got.pixel_on !== want.pixel_on) begin
            $error("pixel_on: expected %0b, actual %0b", want.pixel_on, got.pixel_on);
            faults++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            faults++;
         end
      endfunction

      function int pending_count();
         return pending_pixels.size();
      endfunction
   endclass
endpackage

// ===== tb/tb_viewport_pixel_streamer_rotate.sv =====
`timescale 1ns / 1ps
// Top of the viewport pixel streamer testbench: clock, reset, request, result
// and register drivers. Depends on vps_pkg, vps_tb_pkg and the streamer RTL.
module tb_viewport_pixel_streamer_rotate;
   import vps_pkg::*;
   import vps_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data  = '0;

   pixel_write_tracker board;
   int unsigned        cycles = 0;
   bit                 calm = 1'b0;     // set for the tail of the run: no stalls at all
   bit                 req_gaps_on = 1'b1;
   int                 stall_left = 0;
   int                 quiet_left = 0;

   viewport_pixel_streamer_rotate u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check every pixel transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_pixel(rsp_data);
   end

   // Result side back-pressure: random stall bursts, broken up by quiet stretches.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (quiet_left > 0) begin
         rsp_ready  <= 1'b1;
         quiet_left <= quiet_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
         rsp_ready  <= 1'b1;
         quiet_left <= $urandom_range(20, 80);
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type stream_item(logic [7:0] bits, logic [3:0] count, logic inv);
      req_type r;
      r           = '0;
      r.op        = OP_STREAM;
      r.data_byte = bits;
      r.bit_count = count;
      r.invert    = inv;
      return r;
   endfunction

   function automatic req_type point_item(logic [7:0] x, logic [7:0] y, logic [7:0] lvl);
      req_type r;
      r         = '0;
      r.op      = OP_POINT;
      r.point_x = x;
      r.point_y = y;
      r.level   = lvl;
      return r;
   endfunction

   // Random item: mostly streamed bytes of 1 to 8 bits, some oversize or empty
   // counts, a quarter point writes. Unused fields carry noise too.
   function automatic req_type random_item();
      req_type r;
      int      pick;
      r.op        = ($urandom_range(0, 3) == 0) ? OP_POINT : OP_STREAM;
      r.data_byte = 8'($urandom);
      r.invert    = 1'($urandom);
      r.point_x   = 8'($urandom);
      r.point_y   = 8'($urandom);
      r.level     = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 16)
         r.bit_count = 4'($urandom_range(1, 8));
      else if (pick < 19)
         r.bit_count = 4'($urandom_range(9, 15));
      else
         r.bit_count = 4'd0;
      return r;
   endfunction

   // Drive one item and hold it until the transfer. Valid stays high on return;
   // the caller either sends the next item or drops valid in the same step.
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      if (!calm && req_gaps_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      board.note_request(item);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      board.write_reg(idx, val);
   endtask

   // Wait for every predicted pixel, then give a dropped zero-count byte time to clear.
   task automatic wait_drained();
      while (board.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the registers selected by mask (bit i = register index i) while idle,
   // then stream n random items.
   task automatic run_phase(input cfg_type cfg, input logic [4:0] mask, input int n);
      wait_drained();
      if (mask[0]) write_reg(CSR_ROTATION, {6'd0, cfg.rotation});
      if (mask[1]) write_reg(CSR_VIEW_LEFT, cfg.view_left);
      if (mask[2]) write_reg(CSR_VIEW_TOP, cfg.view_top);
      if (mask[3]) write_reg(CSR_VIEW_RIGHT, cfg.view_right);
      if (mask[4]) write_reg(CSR_VIEW_BOTTOM, cfg.view_bottom);
      if (mask != 5'd0)
         csr_valid <= 1'b0;
      req_gaps_on = ($urandom_range(0, 3) != 0);
      repeat (n) send_item(random_item());
      req_valid <= 1'b0;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.rotation  = rot_type'($urandom_range(0, 3));
      c.view_left = 8'($urandom);
      c.view_top  = 8'($urandom);
      // keep most windows narrow so rows and frames wrap often; the sum may
      // roll over and give an inverted window
      c.view_right  = c.view_left + 8'($urandom_range(0, 12));
      c.view_bottom = c.view_top + 8'($urandom_range(0, 6));
      if ($urandom_range(0, 4) == 0)
         c.view_right = 8'($urandom);
      return c;
   endfunction

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset configuration.
      send_item(stream_item(8'hA5, 4'd8, 1'b0));
      send_item(stream_item(8'hFF, 4'd1, 1'b1));
      send_item(stream_item(8'h00, 4'd8, 1'b1));
      send_item(stream_item(8'hFF, 4'd8, 1'b0));
      send_item(stream_item(8'h5A, 4'd0, 1'b0));    // empty byte: no pixels, cursor holds
      send_item(stream_item(8'h3C, 4'd9, 1'b0));    // oversize counts act as eight
      send_item(stream_item(8'hC3, 4'd15, 1'b1));
      send_item(stream_item(8'h81, 4'd3, 1'b0));
      send_item(point_item(8'd0, 8'd0, 8'd128));    // level threshold, both sides
      send_item(point_item(8'd255, 8'd255, 8'd127));
      send_item(point_item(8'd255, 8'd0, 8'd255));
      send_item(point_item(8'd0, 8'd255, 8'd0));
      begin
         req_type odd;
         // point write must ignore the stream fields
         odd           = point_item(8'd17, 8'd200, 8'd200);
         odd.data_byte = 8'hFF;
         odd.bit_count = 4'hF;
         odd.invert    = 1'b1;
         send_item(odd);
      end
      repeat (6) send_item(stream_item(8'($urandom), 4'd8, 1'($urandom)));
      req_valid <= 1'b0;

      // Fixed settings: full window, inverted window, tiny window, one-pixel window
      // at the range's top corner, a high-x edge window, rotation alone (cursor kept).
      run_phase('{ROT_90, 8'd0, 8'd0, 8'd255, 8'd255}, 5'b11111, 16);
      run_phase('{ROT_180, 8'd200, 8'd20, 8'd10, 8'd5}, 5'b11111, 16);
      run_phase('{ROT_270, 8'd3, 8'd7, 8'd5, 8'd8}, 5'b11111, 16);
      run_phase('{ROT_0, 8'd255, 8'd255, 8'd255, 8'd255}, 5'b11111, 12);
      run_phase('{ROT_180, 8'd250, 8'd0, 8'd255, 8'd1}, 5'b11111, 12);
      run_phase('{ROT_270, 8'd0, 8'd0, 8'd0, 8'd0}, 5'b00001, 12);

      // Random settings, some with only part of the registers rewritten.
      repeat (4) begin
         logic [4:0] mask;
         mask = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'b11111;
         run_phase(random_cfg(), mask, 14);
      end

      // Tail of the run with neither side idling.
      calm = 1'b1;
      run_phase(random_cfg(), 5'b11111, 10);
      run_phase('{ROT_90, 8'd0, 8'd0, 8'd127, 8'd31}, 5'b11111, 10);

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.faults == 0 && board.pending_count() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
